@@ sv/lcdq_pkg.sv @@
// ----------------------------------------------------------------------------
// lcdq_pkg
// Shared types and constants for the character LCD 4-bit instruction queue.
// ----------------------------------------------------------------------------
package lcdq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;

    localparam logic [2:0] NIBBLE_OFFSET_RESET = 3'd4;
    localparam logic [7:0] CMD_MARKER          = 8'h11;
    localparam logic [5:0] ENTRY_MODE_CODE     = 6'b000001;

    // Request selector codes.
    localparam logic [1:0] SEL_PUSH_CMD  = 2'd0;
    localparam logic [1:0] SEL_PUSH_DATA = 2'd1;
    localparam logic [1:0] SEL_POLL      = 2'd2;

    // Response status codes.
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_DROP = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH2,
        S_HEAD,
        S_CMDB,
        S_NIB_HI,
        S_NIB_LO,
        S_RESP
    } state_t;

    typedef enum logic [1:0] {
        WSEL_MARKER,
        WSEL_INPUT,
        WSEL_HELD
    } wsel_t;

    typedef enum logic {
        BSRC_INPUT,
        BSRC_RDATA
    } bsrc_t;

    typedef enum logic [1:0] {
        OUT_RESP,
        OUT_NIB_HI,
        OUT_NIB_LO
    } out_kind_t;

    typedef struct packed {
        logic       wr_en;
        wsel_t      wr_sel;
        logic       pop;
        logic       byte_load;
        bsrc_t      byte_src;
        logic       rs_val;
        logic       flags_update;
        logic       status_we;
        logic [1:0] status_val;
        logic       out_load;
        out_kind_t  out_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic almost_full;
        logic empty;
        logic last_entry;
        logic head_is_marker;
        logic value_is_marker;
        logic value_busy;
        logic out_free;
    } dp_sts_t;

endpackage

@@ sv/lcdq_dp.sv @@
// ----------------------------------------------------------------------------
// lcdq_dp
// Datapath: entry memory with pointers and fill count, held byte, tracked
// LCD state, nibble placement and the response register.
// ----------------------------------------------------------------------------
module lcdq_dp import lcdq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_data,
    input  logic [7:0] value,
    input  dp_cmd_t    dp_cmd,
    output dp_sts_t    dp_sts,
    input  logic       rsp_stall,
    output logic       rsp_valid,
    output logic [1:0] status,
    output logic       write_valid,
    output logic       reg_select,
    output logic [7:0] data_pins,
    output logic       last,
    output logic       pending,
    output logic       addr_in_cgram,
    output logic       cursor_right
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ALMOST = CNT_W'(QUEUE_DEPTH - 2);

    logic [7:0]       mem [QUEUE_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [7:0]       byte_reg, byte_next;
    logic             rs_reg, rs_next;
    logic [1:0]       status_reg, status_next;
    logic             cgram_reg, cgram_next;
    logic             right_reg, right_next;
    logic [2:0]       offset_reg, offset_next;
    logic [7:0]       wr_data;
    logic [3:0]       nibble;
    logic [7:0]       placed;

    logic             rsp_valid_reg, rsp_valid_next;
    logic [1:0]       o_status_reg;
    logic             o_wv_reg, o_rs_reg, o_last_reg, o_pend_reg, o_cgram_reg, o_right_reg;
    logic [7:0]       o_pins_reg;

    always_comb
    begin
        case (dp_cmd.wr_sel)
            WSEL_MARKER: wr_data = CMD_MARKER;
            WSEL_INPUT:  wr_data = value;
            default:     wr_data = byte_reg;
        endcase
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (dp_cmd.wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            fill_next   = fill_reg + 1'b1;
        end
        else if (dp_cmd.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            fill_next   = fill_reg - 1'b1;
        end
    end

    // The read port follows the next head pointer, so after a pop the
    // following entry is already registered in the next cycle.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_ptr_next];
    end

    always_comb
    begin
        byte_next   = byte_reg;
        rs_next     = rs_reg;
        status_next = status_reg;
        cgram_next  = cgram_reg;
        right_next  = right_reg;
        offset_next = cfg_write ? cfg_data : offset_reg;
        if (dp_cmd.byte_load)
        begin
            byte_next = (dp_cmd.byte_src == BSRC_INPUT) ? value : rd_data_reg;
            rs_next   = dp_cmd.rs_val;
        end
        if (dp_cmd.status_we)
        begin
            status_next = dp_cmd.status_val;
        end
        if (dp_cmd.flags_update)
        begin
            if (rd_data_reg[7])
            begin
                cgram_next = 1'b0;
            end
            else if (rd_data_reg[6])
            begin
                cgram_next = 1'b1;
            end
            if (rd_data_reg[7:2] == ENTRY_MODE_CODE)
            begin
                right_next = rd_data_reg[1];
            end
        end
    end

    always_comb
    begin
        nibble = (dp_cmd.out_kind == OUT_NIB_HI) ? byte_reg[7:4] : byte_reg[3:0];
        placed = {4'b0000, nibble} << offset_reg;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (dp_cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            cgram_reg     <= 1'b0;
            right_reg     <= 1'b1;
            offset_reg    <= NIBBLE_OFFSET_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            cgram_reg     <= cgram_next;
            right_reg     <= right_next;
            offset_reg    <= offset_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        rs_reg     <= rs_next;
        status_reg <= status_next;
        if (dp_cmd.out_load)
        begin
            o_status_reg <= status_reg;
            o_wv_reg     <= (dp_cmd.out_kind != OUT_RESP);
            o_rs_reg     <= (dp_cmd.out_kind != OUT_RESP) && rs_reg;
            o_pins_reg   <= (dp_cmd.out_kind != OUT_RESP) ? placed : 8'h00;
            o_last_reg   <= (dp_cmd.out_kind != OUT_NIB_HI);
            o_pend_reg   <= (fill_reg != '0);
            o_cgram_reg  <= cgram_reg;
            o_right_reg  <= right_reg;
        end
    end

    always_comb
    begin
        dp_sts.almost_full     = (fill_reg > CNT_ALMOST);
        dp_sts.empty           = (fill_reg == '0);
        dp_sts.last_entry      = (fill_reg == CNT_W'(1));
        dp_sts.head_is_marker  = (rd_data_reg == CMD_MARKER);
        dp_sts.value_is_marker = (value == CMD_MARKER);
        dp_sts.value_busy      = value[7];
        dp_sts.out_free        = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = o_status_reg;
    assign write_valid   = o_wv_reg;
    assign reg_select    = o_rs_reg;
    assign data_pins     = o_pins_reg;
    assign last          = o_last_reg;
    assign pending       = o_pend_reg;
    assign addr_in_cgram = o_cgram_reg;
    assign cursor_right  = o_right_reg;

endmodule

@@ sv/lcdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcdq_ctrl
// Controller: sequences pushes, head reads, nibble strobes and responses.
// ----------------------------------------------------------------------------
module lcdq_ctrl import lcdq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] cmd,
    input  dp_sts_t    dp_sts,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg, state_next;
    logic   accept;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        SEL_PUSH_CMD:
                            state_next = dp_sts.almost_full ? S_RESP : S_PUSH2;
                        SEL_POLL:
                            state_next = (dp_sts.value_busy || dp_sts.empty) ? S_RESP
                                                                             : S_HEAD;
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end
            S_PUSH2:
                state_next = S_RESP;
            S_HEAD:
            begin
                if (!dp_sts.head_is_marker)
                begin
                    state_next = S_NIB_HI;
                end
                else
                begin
                    state_next = dp_sts.last_entry ? S_RESP : S_CMDB;
                end
            end
            S_CMDB:
                state_next = S_NIB_HI;
            S_NIB_HI:
                if (dp_sts.out_free) state_next = S_NIB_LO;
            S_NIB_LO:
                if (dp_sts.out_free) state_next = S_IDLE;
            S_RESP:
                if (dp_sts.out_free) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        dp_cmd = '{wr_en: 1'b0, wr_sel: WSEL_MARKER, pop: 1'b0, byte_load: 1'b0,
                   byte_src: BSRC_INPUT, rs_val: 1'b0, flags_update: 1'b0,
                   status_we: 1'b0, status_val: STATUS_OK, out_load: 1'b0,
                   out_kind: OUT_RESP};
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    dp_cmd.status_we = 1'b1;
                    unique case (cmd)
                        SEL_PUSH_CMD:
                        begin
                            if (dp_sts.almost_full)
                            begin
                                dp_cmd.status_val = STATUS_FULL;
                            end
                            else
                            begin
                                dp_cmd.wr_en     = 1'b1;
                                dp_cmd.wr_sel    = WSEL_MARKER;
                                dp_cmd.byte_load = 1'b1;
                                dp_cmd.byte_src  = BSRC_INPUT;
                            end
                        end
                        SEL_PUSH_DATA:
                        begin
                            if (dp_sts.almost_full)
                            begin
                                dp_cmd.status_val = STATUS_FULL;
                            end
                            else if (dp_sts.value_is_marker)
                            begin
                                dp_cmd.status_val = STATUS_DROP;
                            end
                            else
                            begin
                                dp_cmd.wr_en  = 1'b1;
                                dp_cmd.wr_sel = WSEL_INPUT;
                            end
                        end
                        default:
                            dp_cmd.status_val = STATUS_OK;
                    endcase
                end
            end
            S_PUSH2:
            begin
                dp_cmd.wr_en  = 1'b1;
                dp_cmd.wr_sel = WSEL_HELD;
            end
            S_HEAD:
            begin
                dp_cmd.pop = 1'b1;
                if (!dp_sts.head_is_marker)
                begin
                    dp_cmd.byte_load = 1'b1;
                    dp_cmd.byte_src  = BSRC_RDATA;
                    dp_cmd.rs_val    = 1'b1;
                end
            end
            S_CMDB:
            begin
                dp_cmd.pop          = 1'b1;
                dp_cmd.byte_load    = 1'b1;
                dp_cmd.byte_src     = BSRC_RDATA;
                dp_cmd.rs_val       = 1'b0;
                dp_cmd.flags_update = 1'b1;
            end
            S_NIB_HI:
            begin
                dp_cmd.out_load = dp_sts.out_free;
                dp_cmd.out_kind = OUT_NIB_HI;
            end
            S_NIB_LO:
            begin
                dp_cmd.out_load = dp_sts.out_free;
                dp_cmd.out_kind = OUT_NIB_LO;
            end
            S_RESP:
            begin
                dp_cmd.out_load = dp_sts.out_free;
                dp_cmd.out_kind = OUT_RESP;
            end
            default:
            begin
                dp_cmd.out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/lcd_instruction_queue_4bit_unit.sv @@
// ----------------------------------------------------------------------------
// lcd_instruction_queue_4bit_unit
// Instruction queue in front of a character LCD driven over a 4-bit bus.
// ----------------------------------------------------------------------------
// Firmware pushes command bytes (stored as a marker entry plus the byte) and
// data bytes (one entry; a data byte equal to the marker is dropped), and
// polls with the device readout. A poll with the busy bit clear sends the
// head instruction as two nibble strobe transactions, high nibble first, with
// the nibble shifted to the configured pin offset. One request is handled at
// a time and the request side stalls until its work is done; the response
// register lets the next request start while the last response waits. A data
// push, a refused push or a poll with nothing to send goes straight to the
// response state, a stored command push first writes the held byte, a data
// dispatch pops the head and then sends both nibbles, and a command dispatch
// also pops the command byte behind its marker. The entry memory has a
// registered read port, so each entry sits in a register before it is used.
// ----------------------------------------------------------------------------
module lcd_instruction_queue_4bit_unit import lcdq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [2:0] cfg_data,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] value,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output logic [1:0] status,
    output logic       write_valid,
    output logic       reg_select,
    output logic [7:0] data_pins,
    output logic       last,
    output logic       pending,
    output logic       addr_in_cgram,
    output logic       cursor_right
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    lcdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .dp_sts    (dp_sts),
        .dp_cmd    (dp_cmd)
    );

    lcdq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .value         (value),
        .dp_cmd        (dp_cmd),
        .dp_sts        (dp_sts),
        .rsp_stall     (rsp_stall),
        .rsp_valid     (rsp_valid),
        .status        (status),
        .write_valid   (write_valid),
        .reg_select    (reg_select),
        .data_pins     (data_pins),
        .last          (last),
        .pending       (pending),
        .addr_in_cgram (addr_in_cgram),
        .cursor_right  (cursor_right)
    );

endmodule
